[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/rtah_pkg.sv]
package rtah_pkg;

   localparam int CoordWidth    = 16;
   localparam int EdgeWidth     = 17;
   localparam int AWidth        = 18;
   localparam int BWidth        = 36;
   localparam int ProdWidth     = AWidth + BWidth;
   localparam int AccWidth      = 56;
   localparam int ThrWidth      = 48;
   localparam int TminWidth     = 16;
   localparam int AnLoWidth     = 16;
   localparam int CsrIndexWidth = 4;
   localparam int StepWidth     = 5;

   localparam logic [StepWidth-1:0]         LastStep = 5'd25;
   localparam logic signed [CoordWidth-1:0] DirZReset = 16'sd256;
   localparam logic [ThrWidth-1:0]          ThrReset = 48'd17;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_ORIGIN_X  = 4'd0,
      REG_ORIGIN_Y  = 4'd1,
      REG_ORIGIN_Z  = 4'd2,
      REG_DIR_X     = 4'd3,
      REG_DIR_Y     = 4'd4,
      REG_DIR_Z     = 4'd5,
      REG_DET_THR   = 4'd6,
      REG_T_MIN     = 4'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      A_DIR_X, A_DIR_Y, A_DIR_Z,
      A_E1_X, A_E1_Y, A_E1_Z,
      A_E2_X, A_E2_Y, A_E2_Z,
      A_T_X, A_T_Y, A_T_Z,
      A_TMIN
   } a_sel_type;

   typedef enum logic [3:0] {
      B_E1_X, B_E1_Y, B_E1_Z,
      B_E2_X, B_E2_Y, B_E2_Z,
      B_P_X, B_P_Y, B_P_Z,
      B_Q_X, B_Q_Y, B_Q_Z,
      B_AN_LO, B_AN_HI
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_FRESH, ACC_ADD, ACC_SHIFT
   } acc_mode_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_P_X, DST_P_Y, DST_P_Z,
      DST_Q_X, DST_Q_Y, DST_Q_Z,
      DST_DET, DST_UN, DST_VN, DST_TN, DST_LIM
   } dest_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH
   } state_type;

   typedef struct packed {
      a_sel_type    a_sel;
      b_sel_type    b_sel;
      acc_mode_type mode;
      logic         negate;
      logic         fold;
      dest_type     dest;
   } step_type;

   typedef struct packed {
      logic     valid;
      step_type step;
   } issue_type;

   typedef struct packed {
      logic     valid;
      dest_type dest;
   } wr_type;

   // multiply-accumulate schedule; fold applies the sign of det
   function automatic step_type step_ctrl(input logic [StepWidth-1:0] idx);
      step_type s;
      s = '{A_DIR_X, B_E1_X, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
      unique case (idx)
         5'd0:  s = '{A_DIR_Y, B_E2_Z, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd1:  s = '{A_DIR_Z, B_E2_Y, ACC_ADD,   1'b1, 1'b0, DST_P_X};
         5'd2:  s = '{A_DIR_Z, B_E2_X, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd3:  s = '{A_DIR_X, B_E2_Z, ACC_ADD,   1'b1, 1'b0, DST_P_Y};
         5'd4:  s = '{A_DIR_X, B_E2_Y, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd5:  s = '{A_DIR_Y, B_E2_X, ACC_ADD,   1'b1, 1'b0, DST_P_Z};
         5'd6:  s = '{A_T_Y,   B_E1_Z, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd7:  s = '{A_T_Z,   B_E1_Y, ACC_ADD,   1'b1, 1'b0, DST_Q_X};
         5'd8:  s = '{A_T_Z,   B_E1_X, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd9:  s = '{A_T_X,   B_E1_Z, ACC_ADD,   1'b1, 1'b0, DST_Q_Y};
         5'd10: s = '{A_T_X,   B_E1_Y, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd11: s = '{A_T_Y,   B_E1_X, ACC_ADD,   1'b1, 1'b0, DST_Q_Z};
         5'd12: s = '{A_E1_X,  B_P_X,  ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd13: s = '{A_E1_Y,  B_P_Y,  ACC_ADD,   1'b0, 1'b0, DST_NONE};
         5'd14: s = '{A_E1_Z,  B_P_Z,  ACC_ADD,   1'b0, 1'b0, DST_DET};
         5'd15: s = '{A_T_X,   B_P_X,  ACC_FRESH, 1'b0, 1'b1, DST_NONE};
         5'd16: s = '{A_T_Y,   B_P_Y,  ACC_ADD,   1'b0, 1'b1, DST_NONE};
         5'd17: s = '{A_T_Z,   B_P_Z,  ACC_ADD,   1'b0, 1'b1, DST_UN};
         5'd18: s = '{A_DIR_X, B_Q_X,  ACC_FRESH, 1'b0, 1'b1, DST_NONE};
         5'd19: s = '{A_DIR_Y, B_Q_Y,  ACC_ADD,   1'b0, 1'b1, DST_NONE};
         5'd20: s = '{A_DIR_Z, B_Q_Z,  ACC_ADD,   1'b0, 1'b1, DST_VN};
         5'd21: s = '{A_E2_X,  B_Q_X,  ACC_FRESH, 1'b0, 1'b1, DST_NONE};
         5'd22: s = '{A_E2_Y,  B_Q_Y,  ACC_ADD,   1'b0, 1'b1, DST_NONE};
         5'd23: s = '{A_E2_Z,  B_Q_Z,  ACC_ADD,   1'b0, 1'b1, DST_TN};
         5'd24: s = '{A_TMIN,  B_AN_LO, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
         5'd25: s = '{A_TMIN,  B_AN_HI, ACC_SHIFT, 1'b0, 1'b0, DST_LIM};
         default: s = '{A_DIR_X, B_E1_X, ACC_FRESH, 1'b0, 1'b0, DST_NONE};
      endcase
      return s;
   endfunction

endpackage

[design/rtah_if.sv]
interface rtah_req_if import rtah_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [CoordWidth-1:0] v1_x;
   logic signed [CoordWidth-1:0] v1_y;
   logic signed [CoordWidth-1:0] v1_z;
   logic signed [CoordWidth-1:0] v2_x;
   logic signed [CoordWidth-1:0] v2_y;
   logic signed [CoordWidth-1:0] v2_z;
   logic signed [CoordWidth-1:0] v3_x;
   logic signed [CoordWidth-1:0] v3_y;
   logic signed [CoordWidth-1:0] v3_z;
   logic                         last_triangle;

   modport source (
      output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, last_triangle,
      input  ready
   );
   modport sink (
      input  valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, last_triangle,
      output ready
   );
endinterface

interface rtah_rsp_if import rtah_pkg::*; ();
   logic valid;
   logic ready;
   logic triangle_hit;
   logic any_hit;
   logic list_done;

   modport source (
      output valid, triangle_hit, any_hit, list_done,
      input  ready
   );
   modport sink (
      input  valid, triangle_hit, any_hit, list_done,
      output ready
   );
endinterface

interface rtah_csr_if import rtah_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [ThrWidth-1:0]      data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

[design/ray_triangle_any_hit.sv]
// Requests are not overlapped: a new request is accepted only after the previous one
// has made its 26 passes through the shared 18x36 multiply-accumulate unit and its
// result has been loaded into the result register.
// The result register lets the next request enter while a result waits.
// Synchronous reset clears control, the hit accumulator and restores registers.
module ray_triangle_any_hit import rtah_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rtah_req_if.sink   req_bus,
   rtah_rsp_if.source rsp_bus,
   rtah_csr_if.sink   csr_bus
);

   logic signed [CoordWidth-1:0] origin_ff [3];
   logic signed [CoordWidth-1:0] dir_ff [3];
   logic [ThrWidth-1:0]          thr_ff;
   logic [TminWidth-1:0]         tmin_ff;

   logic signed [EdgeWidth-1:0]  e1_ff [3];
   logic signed [EdgeWidth-1:0]  e2_ff [3];
   logic signed [EdgeWidth-1:0]  tv_ff [3];
   logic                         last_ff;

   logic signed [BWidth-1:0]     p_ff [3];
   logic signed [BWidth-1:0]     q_ff [3];
   logic signed [AccWidth-1:0]   det_ff;
   logic signed [AccWidth-1:0]   un_ff;
   logic signed [AccWidth-1:0]   vn_ff;
   logic signed [AccWidth-1:0]   tn_ff;
   logic signed [AccWidth-1:0]   lim_ff;
   logic signed [AccWidth-1:0]   an_ff;
   logic signed [AccWidth-1:0]   uv_ff;
   logic signed [AccWidth-1:0]   thr_ext;

   logic                         rsp_valid_ff;
   logic                         hit_ff;
   logic                         any_ff;
   logic                         done_ff;
   logic                         acc_hit_ff;

   logic                         req_ready;
   logic                         start;
   logic                         out_free;
   logic                         load_out;
   issue_type                    issue;
   wr_type                       wr;
   logic signed [AccWidth-1:0]   sum;
   logic signed [AWidth-1:0]     op_a;
   logic signed [BWidth-1:0]     op_b;
   logic                         hit;
   logic                         any_in;

   assign start         = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   rtah_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .ready    (req_ready),
      .issue    (issue),
      .load_out (load_out)
   );

   rtah_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .op_a    (op_a),
      .op_b    (op_b),
      .det_neg (det_ff[AccWidth-1]),
      .wr      (wr),
      .sum     (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= DirZReset;
         thr_ff       <= ThrReset;
         tmin_ff      <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_ORIGIN_X: origin_ff[0] <= csr_bus.data[CoordWidth-1:0];
            REG_ORIGIN_Y: origin_ff[1] <= csr_bus.data[CoordWidth-1:0];
            REG_ORIGIN_Z: origin_ff[2] <= csr_bus.data[CoordWidth-1:0];
            REG_DIR_X:    dir_ff[0]    <= csr_bus.data[CoordWidth-1:0];
            REG_DIR_Y:    dir_ff[1]    <= csr_bus.data[CoordWidth-1:0];
            REG_DIR_Z:    dir_ff[2]    <= csr_bus.data[CoordWidth-1:0];
            REG_DET_THR:  thr_ff       <= csr_bus.data;
            REG_T_MIN:    tmin_ff      <= csr_bus.data[TminWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         e1_ff[0] <= EdgeWidth'(req_bus.v2_x) - EdgeWidth'(req_bus.v1_x);
         e1_ff[1] <= EdgeWidth'(req_bus.v2_y) - EdgeWidth'(req_bus.v1_y);
         e1_ff[2] <= EdgeWidth'(req_bus.v2_z) - EdgeWidth'(req_bus.v1_z);
         e2_ff[0] <= EdgeWidth'(req_bus.v3_x) - EdgeWidth'(req_bus.v1_x);
         e2_ff[1] <= EdgeWidth'(req_bus.v3_y) - EdgeWidth'(req_bus.v1_y);
         e2_ff[2] <= EdgeWidth'(req_bus.v3_z) - EdgeWidth'(req_bus.v1_z);
         tv_ff[0] <= EdgeWidth'(origin_ff[0]) - EdgeWidth'(req_bus.v1_x);
         tv_ff[1] <= EdgeWidth'(origin_ff[1]) - EdgeWidth'(req_bus.v1_y);
         tv_ff[2] <= EdgeWidth'(origin_ff[2]) - EdgeWidth'(req_bus.v1_z);
         last_ff  <= req_bus.last_triangle;
      end
   end

   always_comb begin
      case (issue.step.a_sel)
         A_DIR_X: op_a = AWidth'(dir_ff[0]);
         A_DIR_Y: op_a = AWidth'(dir_ff[1]);
         A_DIR_Z: op_a = AWidth'(dir_ff[2]);
         A_E1_X:  op_a = AWidth'(e1_ff[0]);
         A_E1_Y:  op_a = AWidth'(e1_ff[1]);
         A_E1_Z:  op_a = AWidth'(e1_ff[2]);
         A_E2_X:  op_a = AWidth'(e2_ff[0]);
         A_E2_Y:  op_a = AWidth'(e2_ff[1]);
         A_E2_Z:  op_a = AWidth'(e2_ff[2]);
         A_T_X:   op_a = AWidth'(tv_ff[0]);
         A_T_Y:   op_a = AWidth'(tv_ff[1]);
         A_T_Z:   op_a = AWidth'(tv_ff[2]);
         A_TMIN:  op_a = AWidth'(tmin_ff);
         default: op_a = '0;
      endcase
      case (issue.step.b_sel)
         B_E1_X:  op_b = BWidth'(e1_ff[0]);
         B_E1_Y:  op_b = BWidth'(e1_ff[1]);
         B_E1_Z:  op_b = BWidth'(e1_ff[2]);
         B_E2_X:  op_b = BWidth'(e2_ff[0]);
         B_E2_Y:  op_b = BWidth'(e2_ff[1]);
         B_E2_Z:  op_b = BWidth'(e2_ff[2]);
         B_P_X:   op_b = p_ff[0];
         B_P_Y:   op_b = p_ff[1];
         B_P_Z:   op_b = p_ff[2];
         B_Q_X:   op_b = q_ff[0];
         B_Q_Y:   op_b = q_ff[1];
         B_Q_Z:   op_b = q_ff[2];
         B_AN_LO: op_b = BWidth'(an_ff[AnLoWidth-1:0]);
         B_AN_HI: op_b = an_ff[AnLoWidth+BWidth-1:AnLoWidth];
         default: op_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         case (wr.dest)
            DST_P_X: p_ff[0] <= sum[BWidth-1:0];
            DST_P_Y: p_ff[1] <= sum[BWidth-1:0];
            DST_P_Z: p_ff[2] <= sum[BWidth-1:0];
            DST_Q_X: q_ff[0] <= sum[BWidth-1:0];
            DST_Q_Y: q_ff[1] <= sum[BWidth-1:0];
            DST_Q_Z: q_ff[2] <= sum[BWidth-1:0];
            DST_DET: det_ff  <= sum;
            DST_UN:  un_ff   <= sum;
            DST_VN:  vn_ff   <= sum;
            DST_TN:  tn_ff   <= sum;
            DST_LIM: lim_ff  <= sum;
            default: ;
         endcase
      end
      an_ff <= det_ff[AccWidth-1] ? -det_ff : det_ff;
      uv_ff <= un_ff + vn_ff;
   end

   assign thr_ext = AccWidth'(thr_ff);

   always_comb begin
      hit = (an_ff > thr_ext) &&
            !un_ff[AccWidth-1] && (un_ff <= an_ff) &&
            !vn_ff[AccWidth-1] && (uv_ff <= an_ff) &&
            (tn_ff > lim_ff);
      any_in = acc_hit_ff | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_hit_ff   <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
         acc_hit_ff   <= last_ff ? 1'b0 : any_in;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         hit_ff  <= hit;
         any_ff  <= any_in;
         done_ff <= last_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.triangle_hit = hit_ff;
   assign rsp_bus.any_hit      = any_ff;
   assign rsp_bus.list_done    = done_ff;

endmodule

[design/rtah_mac.sv]
module rtah_mac import rtah_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  issue_type                  issue,
   input  logic signed [AWidth-1:0]   op_a,
   input  logic signed [BWidth-1:0]   op_b,
   input  logic                       det_neg,
   output wr_type                     wr,
   output logic signed [AccWidth-1:0] sum
);

   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [ProdWidth-1:0] prod_in;
   logic                        stage_valid_ff;
   step_type                    stage_ff;
   logic signed [AccWidth-1:0]  acc_ff;
   logic signed [AccWidth-1:0]  base;
   logic signed [AccWidth-1:0]  term;
   logic                        subtract;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= issue.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      stage_ff <= issue.step;
      if (stage_valid_ff) begin
         acc_ff <= sum;
      end
   end

   always_comb begin
      case (stage_ff.mode)
         ACC_FRESH: base = '0;
         ACC_ADD:   base = acc_ff;
         ACC_SHIFT: base = acc_ff >>> AnLoWidth;
         default:   base = '0;
      endcase
      term     = AccWidth'(prod_ff);
      subtract = stage_ff.negate ^ (stage_ff.fold & det_neg);
      sum      = subtract ? (base - term) : (base + term);
   end

   assign wr = '{valid: stage_valid_ff, dest: stage_ff.dest};

endmodule

[design/rtah_seq.sv]
module rtah_seq import rtah_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      out_free,
   output logic      ready,
   output issue_type issue,
   output logic      load_out
);

   state_type             state_ff;
   state_type             state_in;
   logic [StepWidth-1:0]  step_ff;
   logic [StepWidth-1:0]  step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + StepWidth'(1);
            if (step_ff == LastStep) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ready       = (state_ff == ST_IDLE);
      issue.valid = (state_ff == ST_RUN);
      issue.step  = step_ctrl(step_ff);
      load_out    = (state_ff == ST_FINISH) && out_free;
   end

endmodule

[design/rtah_chk.sv]
`include "assert_macros.svh"

module rtah_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic triangle_hit,
   input logic any_hit,
   input logic list_done
);

   // one request in flight: busy right after accept
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `ASSERT_SAME(a_any_covers_hit, clock, reset, rsp_valid && triangle_hit, any_hit)

   // no result can show up the cycle after an accept
   `ASSERT_NEXT(a_no_rsp_after_req, clock, reset,
      req_valid && req_ready && !rsp_valid, !rsp_valid)

   `ASSERT_SAME(a_done_known, clock, reset, rsp_valid, list_done == 1'b0 || list_done == 1'b1)

endmodule

bind ray_triangle_any_hit rtah_chk u_rtah_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .triangle_hit (rsp_bus.triangle_hit),
   .any_hit      (rsp_bus.any_hit),
   .list_done    (rsp_bus.list_done)
);

[bench/ray_triangle_any_hit_tb.sv]
module ray_triangle_any_hit_tb;
   import rtah_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SettleCycles  = 40;
   localparam int WatchdogLimit = 4000;
   localparam int HoldOffCycles = 400;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] v1_x, v1_y, v1_z;
      logic signed [CoordWidth-1:0] v2_x, v2_y, v2_z;
      logic signed [CoordWidth-1:0] v3_x, v3_y, v3_z;
      logic                         last;
   } triangle_type;

   typedef struct packed {
      logic triangle_hit;
      logic any_hit;
      logic list_done;
   } result_type;

   typedef struct packed {
      longint x;
      longint y;
      longint z;
   } vec3_type;

   logic clock;
   logic reset;

   rtah_req_if req_bus ();
   rtah_rsp_if rsp_bus ();
   rtah_csr_if csr_bus ();

   ray_triangle_any_hit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ray registers as the block should hold them
   logic signed [CoordWidth-1:0] ray_org [3];
   logic signed [CoordWidth-1:0] ray_dir [3];
   logic [ThrWidth-1:0]          ray_thr;
   logic [TminWidth-1:0]         ray_tmin;
   logic                         list_hit_acc;

   triangle_type triangle_queue [$];
   result_type   pending_results [$];

   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_off_req;
   logic req_taken;
   int   errors;
   int   n_requests;
   int   n_hits;
   int   n_lists;
   int   n_settings;

   always #1 clock = ~clock;

   function automatic vec3_type vec(input longint x, input longint y, input longint z);
      vec3_type r;
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   function automatic vec3_type vsub(input vec3_type a, input vec3_type b);
      return vec(a.x - b.x, a.y - b.y, a.z - b.z);
   endfunction

   function automatic vec3_type cross_prod(input vec3_type a, input vec3_type b);
      return vec(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
   endfunction

   function automatic longint dot_prod(input vec3_type a, input vec3_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   // two-sided test; divisions by det become compares after folding its sign
   function automatic logic ray_hits_triangle(input triangle_type tr);
      vec3_type a, org, dr, e1, e2, tv, p, q;
      longint   det, an, un, vn, tn;
      u64_type  lim;
      a   = vec(tr.v1_x, tr.v1_y, tr.v1_z);
      org = vec(ray_org[0], ray_org[1], ray_org[2]);
      dr  = vec(ray_dir[0], ray_dir[1], ray_dir[2]);
      e1  = vsub(vec(tr.v2_x, tr.v2_y, tr.v2_z), a);
      e2  = vsub(vec(tr.v3_x, tr.v3_y, tr.v3_z), a);
      tv  = vsub(org, a);
      p   = cross_prod(dr, e2);
      det = dot_prod(e1, p);
      an  = (det < 0) ? -det : det;
      if (u64_type'(an) <= u64_type'(ray_thr)) return 1'b0;
      q  = cross_prod(tv, e1);
      un = dot_prod(tv, p);
      vn = dot_prod(dr, q);
      tn = dot_prod(e2, q);
      if (det < 0) begin
         un = -un;
         vn = -vn;
         tn = -tn;
      end
      if (un < 0 || un > an) return 1'b0;
      if (vn < 0 || un + vn > an) return 1'b0;
      if (tn <= 0) return 1'b0;
      lim = u64_type'(ray_tmin) * (u64_type'(an) >> 16)
          + ((u64_type'(ray_tmin) * (u64_type'(an) & 64'hFFFF)) >> 16);
      return u64_type'(tn) > lim;
   endfunction

   function automatic logic signed [CoordWidth-1:0] clip_coord(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return CoordWidth'(v);
   endfunction

   // mostly triangles scattered around a point on the ray, plus noise and degenerates
   function automatic triangle_type random_triangle();
      triangle_type                 tr;
      int                           aim [3];
      int                           span, s, kind, k;
      logic signed [CoordWidth-1:0] c [9];
      kind = $urandom_range(0, 99);
      s    = int'($urandom_range(0, 640)) - 128;
      case ($urandom_range(0, 2))
         0: begin
            span = $urandom_range(1, 16);
         end
         1: begin
            span = $urandom_range(1, 600);
         end
         default: begin
            span = $urandom_range(1, 12000);
         end
      endcase
      for (k = 0; k < 3; k++)
         aim[k] = int'(ray_org[k]) + ((int'(ray_dir[k]) * s) >>> 8);
      for (k = 0; k < 9; k++)
         c[k] = clip_coord(aim[k % 3] + int'($urandom_range(0, 2 * span)) - span);
      if (kind < 15) begin
         for (k = 0; k < 9; k++) c[k] = CoordWidth'($urandom());
      end else if (kind < 20) begin
         for (k = 0; k < 3; k++) c[3 + k] = c[k];
      end else if (kind < 25) begin
         for (k = 0; k < 3; k++) c[6 + k] = clip_coord(2 * int'(c[3 + k]) - int'(c[k]));
      end else if (kind < 30) begin
         for (k = 0; k < 3; k++) c[6 + k] = clip_coord(int'(c[k]) + int'(ray_dir[k]));
      end
      tr.v1_x = c[0];
      tr.v1_y = c[1];
      tr.v1_z = c[2];
      tr.v2_x = c[3];
      tr.v2_y = c[4];
      tr.v2_z = c[5];
      tr.v3_x = c[6];
      tr.v3_y = c[7];
      tr.v3_z = c[8];
      tr.last = ($urandom_range(0, 3) == 0);
      return tr;
   endfunction

   function automatic logic [ThrWidth-1:0] with_junk(input int v);
      logic [31:0] hi;
      hi = $urandom_range(0, 1) ? 32'($urandom()) : 32'h0;
      return {hi, 16'(v)};
   endfunction

   function automatic logic [ThrWidth-1:0] random_thr();
      if ($urandom_range(0, 1)) return ThrWidth'($urandom_range(0, 64));
      return {16'($urandom()), 32'($urandom())} >> $urandom_range(8, 47);
   endfunction

   task automatic queue_triangle(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                 input logic last);
      triangle_type tr;
      tr.v1_x = CoordWidth'(ax);
      tr.v1_y = CoordWidth'(ay);
      tr.v1_z = CoordWidth'(az);
      tr.v2_x = CoordWidth'(bx);
      tr.v2_y = CoordWidth'(by);
      tr.v2_z = CoordWidth'(bz);
      tr.v3_x = CoordWidth'(cx);
      tr.v3_y = CoordWidth'(cy);
      tr.v3_z = CoordWidth'(cz);
      tr.last = last;
      triangle_queue = {triangle_queue, tr};
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [ThrWidth-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_ORIGIN_X: ray_org[0] = value[CoordWidth-1:0];
         REG_ORIGIN_Y: ray_org[1] = value[CoordWidth-1:0];
         REG_ORIGIN_Z: ray_org[2] = value[CoordWidth-1:0];
         REG_DIR_X:    ray_dir[0] = value[CoordWidth-1:0];
         REG_DIR_Y:    ray_dir[1] = value[CoordWidth-1:0];
         REG_DIR_Z:    ray_dir[2] = value[CoordWidth-1:0];
         REG_DET_THR:  ray_thr    = value;
         REG_T_MIN:    ray_tmin   = value[TminWidth-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_ray(input int ox, oy, oz, dx, dy, dz,
                            input logic [ThrWidth-1:0] thr, input logic [TminWidth-1:0] tmin);
      write_reg(REG_ORIGIN_X, with_junk(ox));
      write_reg(REG_ORIGIN_Y, with_junk(oy));
      write_reg(REG_ORIGIN_Z, with_junk(oz));
      write_reg(REG_DIR_X, with_junk(dx));
      write_reg(REG_DIR_Y, with_junk(dy));
      write_reg(REG_DIR_Z, with_junk(dz));
      write_reg(REG_DET_THR, thr);
      write_reg(REG_T_MIN, with_junk(int'(tmin)));
      // unmapped index, must be dropped
      write_reg(CsrIndexWidth'(int'(REG_T_MIN) + $urandom_range(1, 8)),
                {16'($urandom()), 32'($urandom())});
      n_settings++;
   endtask

   task automatic drain();
      @(posedge clock);
      while (triangle_queue.size() != 0 || req_bus.valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic push_random(input int count);
      repeat (count) triangle_queue = {triangle_queue, random_triangle()};
      drain();
   endtask

   task automatic random_phase(input int count, input logic [ThrWidth-1:0] thr,
                               input logic [TminWidth-1:0] tmin);
      apply_ray(int'($urandom_range(0, 16384)) - 8192, int'($urandom_range(0, 16384)) - 8192,
                int'($urandom_range(0, 16384)) - 8192, int'($urandom_range(0, 1024)) - 512,
                int'($urandom_range(0, 1024)) - 512, int'($urandom_range(0, 1024)) - 512,
                thr, tmin);
      push_random(count);
   endtask

   // request driver
   always @(negedge clock) begin
      triangle_type nxt;
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (triangle_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = triangle_queue.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.v1_x          <= nxt.v1_x;
            req_bus.v1_y          <= nxt.v1_y;
            req_bus.v1_z          <= nxt.v1_z;
            req_bus.v2_x          <= nxt.v2_x;
            req_bus.v2_y          <= nxt.v2_y;
            req_bus.v2_z          <= nxt.v2_z;
            req_bus.v3_x          <= nxt.v3_x;
            req_bus.v3_y          <= nxt.v3_y;
            req_bus.v3_z          <= nxt.v3_z;
            req_bus.last_triangle <= nxt.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold-off whenever hold_off_req changes
   int hold_off_seen = 0;
   int hold_off_left = 0;
   always @(negedge clock) begin
      if (hold_off_seen != hold_off_req) begin
         hold_off_seen = hold_off_req;
         hold_off_left = HoldOffCycles;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      triangle_type seen;
      result_type   want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            seen.v1_x = req_bus.v1_x;
            seen.v1_y = req_bus.v1_y;
            seen.v1_z = req_bus.v1_z;
            seen.v2_x = req_bus.v2_x;
            seen.v2_y = req_bus.v2_y;
            seen.v2_z = req_bus.v2_z;
            seen.v3_x = req_bus.v3_x;
            seen.v3_y = req_bus.v3_y;
            seen.v3_z = req_bus.v3_z;
            seen.last = req_bus.last_triangle;
            want.triangle_hit = ray_hits_triangle(seen);
            want.any_hit      = list_hit_acc | want.triangle_hit;
            want.list_done    = seen.last;
            list_hit_acc      = seen.last ? 1'b0 : want.any_hit;
            pending_results   = {pending_results, want};
            n_requests++;
            if (want.triangle_hit) n_hits++;
            if (seen.last) n_lists++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.triangle_hit !== want.triangle_hit) begin
                  $error("triangle_hit: expected %0b, actual %0b",
                         want.triangle_hit, rsp_bus.triangle_hit);
                  errors++;
               end
               if (rsp_bus.any_hit !== want.any_hit) begin
                  $error("any_hit: expected %0b, actual %0b", want.any_hit, rsp_bus.any_hit);
                  errors++;
               end
               if (rsp_bus.list_done !== want.list_done) begin
                  $error("list_done: expected %0b, actual %0b",
                         want.list_done, rsp_bus.list_done);
                  errors++;
               end
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.v1_x          = '0;
      req_bus.v1_y          = '0;
      req_bus.v1_z          = '0;
      req_bus.v2_x          = '0;
      req_bus.v2_y          = '0;
      req_bus.v2_z          = '0;
      req_bus.v3_x          = '0;
      req_bus.v3_y          = '0;
      req_bus.v3_z          = '0;
      req_bus.last_triangle = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      ray_org               = '{3{16'sd0}};
      ray_dir               = '{16'sd0, 16'sd0, DirZReset};
      ray_thr               = ThrReset;
      ray_tmin              = '0;
      list_hit_acc          = 1'b0;
      hold_off_req          = 0;
      errors                = 0;
      n_requests            = 0;
      n_hits                = 0;
      n_lists               = 0;
      n_settings            = 1;
      send_idle_pct         = 20;
      recv_idle_pct         = 84;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset ray: origin 0, direction +z
      queue_triangle(-256, -256, 128, 512, -256, 128, -256, 512, 128, 1'b0);
      queue_triangle(-256, -256, 128, -256, 512, 128, 512, -256, 128, 1'b0);
      queue_triangle(-256, -256, -128, 512, -256, -128, -256, 512, -128, 1'b1);
      queue_triangle(-256, -256, 0, 512, -256, 0, -256, 512, 0, 1'b1);
      queue_triangle(0, 0, 128, 256, 0, 128, 0, 256, 128, 1'b0);
      queue_triangle(-256, -256, 128, 256, -256, 128, -256, 256, 128, 1'b1);
      queue_triangle(-256, -256, 128, 255, -256, 128, -256, 255, 128, 1'b1);
      queue_triangle(0, -256, 128, 256, 0, 128, 0, 256, 128, 1'b0);
      queue_triangle(1, -256, 128, 256, 0, 128, 1, 256, 128, 1'b1);
      queue_triangle(-256, -256, 128, -256, -256, 128, -256, 512, 128, 1'b0);
      queue_triangle(0, 0, 0, 256, 0, 0, 0, 0, 256, 1'b1);
      queue_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, -32768, -32768, 1'b0);
      queue_triangle(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
      queue_triangle(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0, 1'b1);
      queue_triangle(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767, 1'b1);
      drain();
      // determinant magnitude of the first triangle sits exactly on the threshold
      write_reg(REG_DET_THR, 48'd150994944);
      queue_triangle(-256, -256, 128, 512, -256, 128, -256, 512, 128, 1'b1);
      drain();
      write_reg(REG_DET_THR, 48'd150994943);
      queue_triangle(-256, -256, 128, 512, -256, 128, -256, 512, 128, 1'b1);
      drain();
      // hit distance exactly one half
      write_reg(REG_T_MIN, 48'd32768);
      queue_triangle(-256, -256, 128, 512, -256, 128, -256, 512, 128, 1'b0);
      queue_triangle(-256, -256, 129, 512, -256, 129, -256, 512, 129, 1'b1);
      drain();
      write_reg(REG_T_MIN, 48'd32767);
      queue_triangle(-256, -256, 128, 512, -256, 128, -256, 512, 128, 1'b1);
      drain();

      random_phase(200, 48'd17, '0);
      apply_ray(-32768, -32768, -32768, 32767, 32767, 32767, '0, '0);
      push_random(150);
      apply_ray(32767, 32767, 32767, -32768, -32768, -32768, '0, 16'hFFFF);
      push_random(150);

      send_idle_pct = 84;
      recv_idle_pct = 20;
      random_phase(60, {ThrWidth{1'b1}}, '0);
      random_phase(220, random_thr(), 16'($urandom()));
      random_phase(220, random_thr(), 16'($urandom_range(0, 2048)));

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_ray(int'($urandom_range(0, 2048)) - 1024, int'($urandom_range(0, 2048)) - 1024,
                int'($urandom_range(0, 2048)) - 1024, int'($urandom_range(0, 1024)) - 512,
                int'($urandom_range(0, 1024)) - 512, int'($urandom_range(0, 1024)) - 512,
                random_thr(), '0);
      hold_off_req++;
      push_random(220);
      random_phase(200, random_thr(), '0);

      $display("Ran %0d triangle requests in %0d lists over %0d ray settings, %0d hits",
               n_requests, n_lists, n_settings, n_hits);
      $display("Settings included extreme origins, directions, thresholds and t_min values");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/rtah_pkg.sv
design/rtah_if.sv
design/rtah_mac.sv
design/rtah_seq.sv
design/ray_triangle_any_hit.sv
design/rtah_chk.sv
bench/ray_triangle_any_hit_tb.sv
